### rtl/circular_list_free_pool_defines.svh
// ----------------------------------------------------------------------------
// circular_list_free_pool_defines.svh
// assertion macros shared by the free pool list modules
// ----------------------------------------------------------------------------
`ifndef CIRCULAR_LIST_FREE_POOL_DEFINES_SVH
`define CIRCULAR_LIST_FREE_POOL_DEFINES_SVH

`ifndef NO_ASSERTIONS

// checked on every clock edge outside reset
`define CLFP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// checked on every clock edge, reset included
`define CLFP_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define CLFP_ASSERT(lbl, prop, msg)
`define CLFP_ASSERT_ALWAYS(lbl, prop, msg)

`endif

`endif

### rtl/clfp_pkg.sv
// ----------------------------------------------------------------------------
// clfp_pkg
// shared constants, codes and control types of the free pool list
// ----------------------------------------------------------------------------
package clfp_pkg;

  localparam int POOL_NODES_DEF = 64;
  localparam int ITEM_W         = 32;
  localparam int CMD_W          = 3;
  localparam int STATUS_W       = 2;

  // command codes
  localparam logic [CMD_W-1:0] CMD_INSERT     = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REM_CUR    = 3'd1;
  localparam logic [CMD_W-1:0] CMD_REM_HANDLE = 3'd2;
  localparam logic [CMD_W-1:0] CMD_ADVANCE    = 3'd3;
  localparam logic [CMD_W-1:0] CMD_SET_CUR    = 3'd4;
  localparam logic [CMD_W-1:0] CMD_READ       = 3'd5;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] ST_EXHAUSTED = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY     = 2'd2;

  // link memory read address
  typedef enum logic [1:0] {RA_CUR, RA_FREE, RA_HIN, RA_RD} ra_sel_t;
  // link memory write address
  typedef enum logic [1:0] {WA_CLR, WA_T, WA_CUR, WA_X} wa_sel_t;
  // link memory write data
  typedef enum logic [1:0] {WD_CLR, WD_T, WD_RD, WD_FREE} wd_sel_t;
  // register updates
  typedef enum logic [2:0] {CS_HOLD, CS_ZERO, CS_T, CS_X, CS_HIN, CS_RD} cur_sel_t;
  typedef enum logic [1:0] {FS_HOLD, FS_RD, FS_X, FS_T} free_sel_t;
  typedef enum logic [1:0] {TS_HOLD, TS_FREE, TS_RD} t_sel_t;
  typedef enum logic [1:0] {XS_HOLD, XS_CUR, XS_HIN} x_sel_t;

  typedef struct packed {
    logic                ld_in;
    logic                rd_en;
    ra_sel_t             ra;
    logic                we;
    wa_sel_t             wa;
    wd_sel_t             wd;
    logic                item_we;
    logic                item_re;
    cur_sel_t            cur_sel;
    free_sel_t           free_sel;
    t_sel_t              t_sel;
    x_sel_t              x_sel;
    logic                st_ld;
    logic [STATUS_W-1:0] st_code;
    logic                out_ld;
    logic                clr_en;
  } ctl_cmd_t;

  typedef struct packed {
    logic [CMD_W-1:0] cmd;
    logic             cur_zero;
    logic             free_zero;
    logic             hin_zero;
    logic             hin_in_pool;
    logic             rd_eq_x;
    logic             rd_zero;
    logic             cur_eq_x;
    logic             cur_eq_t;
    logic             clr_last;
    logic             slot_free;
  } dp_stat_t;

endpackage

### rtl/clfp_ram.sv
// ----------------------------------------------------------------------------
// clfp_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module clfp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

### rtl/clfp_dp.sv
// ----------------------------------------------------------------------------
// clfp_dp
// datapath: link and item memories, list registers, result register
// ----------------------------------------------------------------------------
`include "circular_list_free_pool_defines.svh"

module clfp_dp #(
  parameter int POOL_NODES = clfp_pkg::POOL_NODES_DEF,
  localparam int HW = $clog2(POOL_NODES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  clfp_pkg::ctl_cmd_t                  ctl,
  output clfp_pkg::dp_stat_t                  stat,
  input  logic [clfp_pkg::CMD_W-1:0]          in_command,
  input  logic signed [clfp_pkg::ITEM_W-1:0]  in_value,
  input  logic [HW-1:0]                       in_handle,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clfp_pkg::STATUS_W-1:0]       out_status,
  output logic [HW-1:0]                       out_current_handle,
  output logic signed [clfp_pkg::ITEM_W-1:0]  out_current_value,
  output logic [HW-1:0]                       out_next_handle
);

  localparam logic [HW-1:0] NODES = HW'(POOL_NODES);

  logic [clfp_pkg::CMD_W-1:0]    cmd_r;
  logic [clfp_pkg::ITEM_W-1:0]   val_r;
  logic [HW-1:0]                 hin_r;
  logic [HW-1:0]                 cur_r, cur_nxt;
  logic [HW-1:0]                 free_r, free_nxt;
  logic [HW-1:0]                 t_r, t_nxt;
  logic [HW-1:0]                 x_r, x_nxt;
  logic [HW-1:0]                 clr_r, clr_nxt;
  logic [clfp_pkg::STATUS_W-1:0] st_r;

  logic                          out_valid_r, out_valid_nxt;
  logic [clfp_pkg::STATUS_W-1:0] out_status_r;
  logic [HW-1:0]                 out_handle_r;
  logic [clfp_pkg::ITEM_W-1:0]   out_value_r;
  logic [HW-1:0]                 out_next_r;

  logic [HW-1:0]               link_raddr, link_waddr, link_wdata, link_rdata, clr_data;
  logic [clfp_pkg::ITEM_W-1:0] item_rdata;

  // reset image of the free chain: 1 -> 2 -> ... -> last -> 0
  assign clr_data = ((clr_r != '0) && (clr_r != NODES)) ? clr_r + HW'(1) : '0;

  always_comb begin
    case (ctl.ra)
      clfp_pkg::RA_CUR:  link_raddr = cur_r;
      clfp_pkg::RA_FREE: link_raddr = free_r;
      clfp_pkg::RA_HIN:  link_raddr = hin_r;
      clfp_pkg::RA_RD:   link_raddr = link_rdata;
      default:           link_raddr = cur_r;
    endcase
    case (ctl.wa)
      clfp_pkg::WA_CLR: link_waddr = clr_r;
      clfp_pkg::WA_T:   link_waddr = t_r;
      clfp_pkg::WA_CUR: link_waddr = cur_r;
      clfp_pkg::WA_X:   link_waddr = x_r;
      default:          link_waddr = clr_r;
    endcase
    case (ctl.wd)
      clfp_pkg::WD_CLR:  link_wdata = clr_data;
      clfp_pkg::WD_T:    link_wdata = t_r;
      clfp_pkg::WD_RD:   link_wdata = link_rdata;
      clfp_pkg::WD_FREE: link_wdata = free_r;
      default:           link_wdata = clr_data;
    endcase
  end

  clfp_ram #(
    .WIDTH (HW),
    .DEPTH (POOL_NODES + 1)
  ) u_link_ram (
    .clk   (clk),
    .we    (ctl.we),
    .waddr (link_waddr),
    .wdata (link_wdata),
    .re    (ctl.rd_en),
    .raddr (link_raddr),
    .rdata (link_rdata)
  );

  clfp_ram #(
    .WIDTH (clfp_pkg::ITEM_W),
    .DEPTH (POOL_NODES + 1)
  ) u_item_ram (
    .clk   (clk),
    .we    (ctl.item_we),
    .waddr (free_r),
    .wdata (val_r),
    .re    (ctl.item_re),
    .raddr (cur_r),
    .rdata (item_rdata)
  );

  always_comb begin
    case (ctl.cur_sel)
      clfp_pkg::CS_HOLD: cur_nxt = cur_r;
      clfp_pkg::CS_ZERO: cur_nxt = '0;
      clfp_pkg::CS_T:    cur_nxt = t_r;
      clfp_pkg::CS_X:    cur_nxt = x_r;
      clfp_pkg::CS_HIN:  cur_nxt = hin_r;
      clfp_pkg::CS_RD:   cur_nxt = link_rdata;
      default:           cur_nxt = cur_r;
    endcase
    case (ctl.free_sel)
      clfp_pkg::FS_HOLD: free_nxt = free_r;
      clfp_pkg::FS_RD:   free_nxt = link_rdata;
      clfp_pkg::FS_X:    free_nxt = x_r;
      clfp_pkg::FS_T:    free_nxt = t_r;
      default:           free_nxt = free_r;
    endcase
    case (ctl.t_sel)
      clfp_pkg::TS_HOLD: t_nxt = t_r;
      clfp_pkg::TS_FREE: t_nxt = free_r;
      clfp_pkg::TS_RD:   t_nxt = link_rdata;
      default:           t_nxt = t_r;
    endcase
    case (ctl.x_sel)
      clfp_pkg::XS_HOLD: x_nxt = x_r;
      clfp_pkg::XS_CUR:  x_nxt = cur_r;
      clfp_pkg::XS_HIN:  x_nxt = hin_r;
      default:           x_nxt = x_r;
    endcase
  end

  assign clr_nxt       = ctl.clr_en ? clr_r + HW'(1) : clr_r;
  assign out_valid_nxt = ctl.out_ld | (out_valid_r & ~out_ready);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_r       <= '0;
      free_r      <= HW'(1);
      clr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      cur_r       <= cur_nxt;
      free_r      <= free_nxt;
      clr_r       <= clr_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    t_r <= t_nxt;
    x_r <= x_nxt;
    if (ctl.ld_in) begin
      cmd_r <= in_command;
      val_r <= in_value;
      hin_r <= in_handle;
    end
    if (ctl.st_ld) begin
      st_r <= ctl.st_code;
    end
    if (ctl.out_ld) begin
      out_status_r <= st_r;
      out_handle_r <= cur_r;
      out_value_r  <= (cur_r == '0) ? '0 : item_rdata;
      out_next_r   <= (cur_r == '0) ? '0 : link_rdata;
    end
  end

  assign stat.cmd         = cmd_r;
  assign stat.cur_zero    = (cur_r == '0);
  assign stat.free_zero   = (free_r == '0);
  assign stat.hin_zero    = (hin_r == '0);
  assign stat.hin_in_pool = (hin_r <= NODES);
  assign stat.rd_eq_x     = (link_rdata == x_r);
  assign stat.rd_zero     = (link_rdata == '0);
  assign stat.cur_eq_x    = (cur_r == x_r);
  assign stat.cur_eq_t    = (cur_r == t_r);
  assign stat.clr_last    = (clr_r == NODES);
  assign stat.slot_free   = ~out_valid_r | out_ready;

  assign out_valid          = out_valid_r;
  assign out_status         = out_status_r;
  assign out_current_handle = out_handle_r;
  assign out_current_value  = out_value_r;
  assign out_next_handle    = out_next_r;

  `CLFP_ASSERT(a_link_wr_in_pool, ctl.we |-> (link_waddr <= NODES), "link write outside pool")
  `CLFP_ASSERT(a_empty_result_zero, (out_valid_r && (out_handle_r == '0)) |-> ((out_next_r == '0) && (out_value_r == '0)), "empty list result not zeroed")

endmodule

### rtl/clfp_ctrl.sv
// ----------------------------------------------------------------------------
// clfp_ctrl
// controller: sequences memory reads and writes for each command
// ----------------------------------------------------------------------------
`include "circular_list_free_pool_defines.svh"

module clfp_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  clfp_pkg::dp_stat_t stat,
  output clfp_pkg::ctl_cmd_t ctl
);

  typedef enum logic [11:0] {
    S_CLEAR = 12'b000000000001,
    S_IDLE  = 12'b000000000010,
    S_START = 12'b000000000100,
    S_INS_A = 12'b000000001000,
    S_INS_B = 12'b000000010000,
    S_INS_C = 12'b000000100000,
    S_RM_A  = 12'b000001000000,
    S_RM_B  = 12'b000010000000,
    S_RM_C  = 12'b000100000000,
    S_ADV   = 12'b001000000000,
    S_FETCH = 12'b010000000000,
    S_DONE  = 12'b100000000000
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    state_nxt = state_r;
    ctl       = '0;
    in_ready  = 1'b0;
    case (state_r)
      S_CLEAR: begin
        ctl.we     = 1'b1;
        ctl.wa     = clfp_pkg::WA_CLR;
        ctl.wd     = clfp_pkg::WD_CLR;
        ctl.clr_en = 1'b1;
        if (stat.clr_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        in_ready   = 1'b1;
        ctl.ld_in  = in_valid;
        if (in_valid) begin
          state_nxt = S_START;
        end
      end
      S_START: begin
        ctl.st_ld   = 1'b1;
        ctl.st_code = clfp_pkg::ST_OK;
        state_nxt   = S_FETCH;
        if (stat.cmd == clfp_pkg::CMD_INSERT) begin
          if (stat.free_zero) begin
            ctl.st_code = clfp_pkg::ST_EXHAUSTED;
          end else begin
            // take the free head: fetch its successor, store the item
            ctl.rd_en   = 1'b1;
            ctl.ra      = clfp_pkg::RA_FREE;
            ctl.item_we = 1'b1;
            ctl.t_sel   = clfp_pkg::TS_FREE;
            state_nxt   = S_INS_A;
          end
        end else if (stat.cmd == clfp_pkg::CMD_SET_CUR) begin
          if (stat.hin_in_pool) begin
            ctl.cur_sel = clfp_pkg::CS_HIN;
          end
        end else if (stat.cur_zero) begin
          ctl.st_code = clfp_pkg::ST_EMPTY;
        end else begin
          case (stat.cmd)
            clfp_pkg::CMD_REM_CUR: begin
              ctl.rd_en = 1'b1;
              ctl.ra    = clfp_pkg::RA_CUR;
              ctl.x_sel = clfp_pkg::XS_CUR;
              state_nxt = S_RM_A;
            end
            clfp_pkg::CMD_REM_HANDLE: begin
              if (!stat.hin_zero && stat.hin_in_pool) begin
                ctl.rd_en = 1'b1;
                ctl.ra    = clfp_pkg::RA_HIN;
                ctl.x_sel = clfp_pkg::XS_HIN;
                state_nxt = S_RM_A;
              end
            end
            clfp_pkg::CMD_ADVANCE: begin
              ctl.rd_en = 1'b1;
              ctl.ra    = clfp_pkg::RA_CUR;
              state_nxt = S_ADV;
            end
            clfp_pkg::CMD_READ: begin
              state_nxt = S_FETCH;
            end
            default: begin
              state_nxt = S_FETCH;
            end
          endcase
        end
      end
      S_INS_A: begin
        ctl.free_sel = clfp_pkg::FS_RD;
        if (stat.cur_zero) begin
          // first node links to itself
          ctl.we      = 1'b1;
          ctl.wa      = clfp_pkg::WA_T;
          ctl.wd      = clfp_pkg::WD_T;
          ctl.cur_sel = clfp_pkg::CS_T;
          state_nxt   = S_FETCH;
        end else begin
          ctl.rd_en = 1'b1;
          ctl.ra    = clfp_pkg::RA_CUR;
          state_nxt = S_INS_B;
        end
      end
      S_INS_B: begin
        ctl.we    = 1'b1;
        ctl.wa    = clfp_pkg::WA_T;
        ctl.wd    = clfp_pkg::WD_RD;
        state_nxt = S_INS_C;
      end
      S_INS_C: begin
        ctl.we      = 1'b1;
        ctl.wa      = clfp_pkg::WA_CUR;
        ctl.wd      = clfp_pkg::WD_T;
        ctl.cur_sel = clfp_pkg::CS_T;
        state_nxt   = S_FETCH;
      end
      S_RM_A: begin
        state_nxt = S_FETCH;
        if (stat.rd_eq_x) begin
          // node points to itself: release it alone
          ctl.we       = 1'b1;
          ctl.wa       = clfp_pkg::WA_X;
          ctl.wd       = clfp_pkg::WD_FREE;
          ctl.free_sel = clfp_pkg::FS_X;
          if (stat.cur_eq_x) begin
            ctl.cur_sel = clfp_pkg::CS_ZERO;
          end
        end else if (!stat.rd_zero) begin
          ctl.t_sel = clfp_pkg::TS_RD;
          ctl.rd_en = 1'b1;
          ctl.ra    = clfp_pkg::RA_RD;
          state_nxt = S_RM_B;
        end
      end
      S_RM_B: begin
        // bypass the removed node
        ctl.we    = 1'b1;
        ctl.wa    = clfp_pkg::WA_X;
        ctl.wd    = clfp_pkg::WD_RD;
        state_nxt = S_RM_C;
      end
      S_RM_C: begin
        ctl.we       = 1'b1;
        ctl.wa       = clfp_pkg::WA_T;
        ctl.wd       = clfp_pkg::WD_FREE;
        ctl.free_sel = clfp_pkg::FS_T;
        if (stat.cur_eq_t) begin
          ctl.cur_sel = clfp_pkg::CS_X;
        end
        state_nxt = S_FETCH;
      end
      S_ADV: begin
        ctl.cur_sel = clfp_pkg::CS_RD;
        state_nxt   = S_FETCH;
      end
      S_FETCH: begin
        ctl.rd_en   = 1'b1;
        ctl.ra      = clfp_pkg::RA_CUR;
        ctl.item_re = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (stat.slot_free) begin
          ctl.out_ld = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  `CLFP_ASSERT(a_one_at_a_time, (in_valid && in_ready) |=> !in_ready, "new beat taken while busy")
  `CLFP_ASSERT_ALWAYS(a_load_into_free_slot, ctl.out_ld |-> stat.slot_free, "result overwrote pending beat")
  `CLFP_ASSERT(a_no_write_and_fetch, ctl.item_re |-> !ctl.we, "link write during result fetch")

endmodule

### rtl/circular_list_free_pool.sv
// ----------------------------------------------------------------------------
// circular_list_free_pool
// circular singly linked list in a fixed node pool with a free chain
// ----------------------------------------------------------------------------
// Keeps one circular list of 32-bit items in POOL_NODES nodes, handles 1 to
// POOL_NODES, handle 0 meaning none. Each input beat carries one command
// (insert after current, remove after current, remove after handle, advance,
// set current, read) and produces exactly one result beat with status, the
// current handle, its item and its successor. After reset the block runs a
// clearing pass over every link address that rebuilds the free chain in the
// link memory; in_ready stays low until it ends. Read, set current, an empty
// list and an exhausted pool pass through the fewest controller states from
// acceptance to the next acceptance, insert into a non-empty list and
// remove with relink the most, because the link memory has one write port
// and a registered read, so each dependent read and each link write takes
// a state of its own. A finished result sits in an output register, so the
// next command is accepted while it waits for out_ready.
// ----------------------------------------------------------------------------
module circular_list_free_pool #(
  parameter int POOL_NODES = clfp_pkg::POOL_NODES_DEF,
  localparam int HW = $clog2(POOL_NODES + 1)
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // command beats
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [clfp_pkg::CMD_W-1:0]          in_command,
  input  logic signed [clfp_pkg::ITEM_W-1:0]  in_value,
  input  logic [HW-1:0]                       in_handle,
  // result beats
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [clfp_pkg::STATUS_W-1:0]       out_status,
  output logic [HW-1:0]                       out_current_handle,
  output logic signed [clfp_pkg::ITEM_W-1:0]  out_current_value,
  output logic [HW-1:0]                       out_next_handle
);

  // command and status bundles between controller and datapath
  clfp_pkg::ctl_cmd_t ctl;
  clfp_pkg::dp_stat_t stat;

  // state machine: clearing pass, decode, read / relink steps, result fetch
  clfp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  // link and item memories, current / free head registers, result register
  clfp_dp #(
    .POOL_NODES (POOL_NODES)
  ) u_dp (
    .clk                (clk),
    .rst_n              (rst_n),
    .ctl                (ctl),
    .stat               (stat),
    .in_command         (in_command),
    .in_value           (in_value),
    .in_handle          (in_handle),
    .out_valid          (out_valid),
    .out_ready          (out_ready),
    .out_status         (out_status),
    .out_current_handle (out_current_handle),
    .out_current_value  (out_current_value),
    .out_next_handle    (out_next_handle)
  );

endmodule
